// ===== src/rg32_pkg.sv =====
// Shared types, constants and round functions for the RadioGatun[32] hash core.
package rg32_pkg;

  localparam int MILL_WORDS            = 19;
  localparam int BELT_COLS             = 13;
  localparam int BELT_ROWS             = 3;
  localparam int FINAL_ROUNDS          = 17;
  localparam int MAX_OUT_WORDS_DEFAULT = 64;
  localparam int OUT_WORDS_RESET       = 8;
  localparam int QUEUE_DEPTH           = 2;
  localparam int QUEUE_PTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W           = $clog2(QUEUE_DEPTH + 1);

  typedef logic [31:0] word_t;
  typedef word_t [MILL_WORDS-1:0] mill_t;
  typedef word_t [BELT_ROWS*BELT_COLS-1:0] belt_t;

  typedef struct packed {
    mill_t mill;
    belt_t belt;
  } rg_state_t;

  localparam word_t MILL_PAD = 32'h0000_0001;
  localparam word_t PAD_WORD = 32'h0000_0001;

  // Item classes handed from the front to the back
  typedef enum logic [1:0] {
    OP_WORD,         // plain message word
    OP_FINAL_PADDED, // final word with pad byte already merged in
    OP_FINAL_FULL    // final word with four bytes; pad word follows
  } op_e;

  typedef struct packed {
    word_t word;
    op_e   op;
  } q_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUNDS,
    ST_SQUEEZE
  } back_state_e;

  // Source mill word for each lane of the gamma/pi step: (7*i) mod 19
  localparam int MILL_IDX [MILL_WORDS] = '{
    0, 7, 14, 2, 9, 16, 4, 11, 18, 6, 13, 1, 8, 15, 3, 10, 17, 5, 12
  };

  // Rotate amount for each lane: i*(i+1)/2 mod 32
  localparam int ROT_AMT [MILL_WORDS] = '{
    0, 1, 3, 6, 10, 15, 21, 28, 4, 13, 23, 2, 14, 27, 9, 24, 8, 25, 11
  };

  function automatic word_t rotr(word_t x, int n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

  function automatic int wrap19(int v);
    int r;
    r = v;
    if (r >= MILL_WORDS) r = r - MILL_WORDS;
    return r;
  endfunction

  // One belt-mill round
  function automatic rg_state_t rg_round(rg_state_t s);
    mill_t     m;
    mill_t     a;
    mill_t     nm;
    belt_t     b;
    belt_t     nb;
    word_t     k;
    int        i;
    int        r;
    int        c;
    int        row;
    int        idx;
    rg_state_t res;
    m   = s.mill;
    b   = s.belt;
    row = 0;
    // mill feeds the belt
    for (i = 0; i < 12; i++) begin
      b[row*BELT_COLS + i] = b[row*BELT_COLS + i] ^ m[i+1];
      row = (row == 2) ? 0 : row + 1;
    end
    // belt rows rotate by one column
    for (r = 0; r < BELT_ROWS; r++) begin
      for (c = 0; c < BELT_COLS; c++) begin
        if (c == 0) nb[r*BELT_COLS] = b[r*BELT_COLS + BELT_COLS - 1];
        else        nb[r*BELT_COLS + c] = b[r*BELT_COLS + c - 1];
      end
    end
    for (i = 0; i < MILL_WORDS; i++) begin
      idx  = MILL_IDX[i];
      k    = m[idx] ^ (m[wrap19(idx + 1)] | ~m[wrap19(idx + 2)]);
      a[i] = rotr(k, ROT_AMT[i]);
    end
    for (i = 0; i < MILL_WORDS; i++) begin
      nm[i] = a[i] ^ a[wrap19(i + 1)] ^ a[wrap19(i + 4)];
    end
    nm[0] = nm[0] ^ MILL_PAD;
    // belt feeds the mill
    for (r = 0; r < BELT_ROWS; r++) begin
      nm[13 + r] = nm[13 + r] ^ nb[r*BELT_COLS];
    end
    res.mill = nm;
    res.belt = nb;
    return res;
  endfunction

  // XOR one word into belt row pos and mill word 16+pos
  function automatic rg_state_t rg_absorb(rg_state_t s, logic [1:0] pos, word_t w);
    rg_state_t res;
    res = s;
    case (pos)
      2'd0: begin
        res.belt[0]  = s.belt[0] ^ w;
        res.mill[16] = s.mill[16] ^ w;
      end
      2'd1: begin
        res.belt[BELT_COLS] = s.belt[BELT_COLS] ^ w;
        res.mill[17]        = s.mill[17] ^ w;
      end
      default: begin
        res.belt[2*BELT_COLS] = s.belt[2*BELT_COLS] ^ w;
        res.mill[18]          = s.mill[18] ^ w;
      end
    endcase
    return res;
  endfunction

endpackage

// ===== src/rg32_front.sv =====
// Front end: accepts message items, applies final-word padding, queues them for the back end.
module rg32_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rg32_pkg::word_t   msg_word_i,
  input  logic [2:0]        byte_count_i,
  input  logic              final_req_i,
  output logic              q_valid_o,
  output rg32_pkg::q_entry_t q_entry_o,
  input  logic              q_ready_i
);
  import rg32_pkg::*;

  q_entry_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   push, pop;
  q_entry_t               entry;

  // Classify the item and merge the pad byte for a short final word
  always_comb begin
    entry.word = msg_word_i;
    entry.op   = OP_WORD;
    if (final_req_i) begin
      entry.op = OP_FINAL_PADDED;
      case (byte_count_i)
        3'd0:    entry.word = PAD_WORD;
        3'd1:    entry.word = {16'h0000, 8'h01, msg_word_i[7:0]};
        3'd2:    entry.word = {8'h00, 8'h01, msg_word_i[15:0]};
        3'd3:    entry.word = {8'h01, msg_word_i[23:0]};
        default: entry.op   = OP_FINAL_FULL;
      endcase
    end
  end

  assign in_ready_o = (cnt_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

endmodule

// ===== src/rg32_back.sv =====
// Back end: belt-mill state, absorb, blank rounds, squeeze and the output register.
module rg32_back #(
  parameter int MAX_OUTPUT_WORDS = rg32_pkg::MAX_OUT_WORDS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_output_words_i,
  input  logic               q_valid_i,
  input  rg32_pkg::q_entry_t q_entry_i,
  output logic               q_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rg32_pkg::word_t    hash_word_o,
  output logic               last_word_o
);
  import rg32_pkg::*;

  localparam int CNT_W = $clog2(MAX_OUTPUT_WORDS + 1);
  localparam int RND_W = $clog2(FINAL_ROUNDS);

  back_state_e      st_q, st_d;
  rg_state_t        hs_q, hs_d;
  logic [1:0]       pos_q, pos_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic [CNT_W-1:0] sq_q, sq_d;
  logic [6:0]       out_words_q;
  logic             out_valid_q, out_valid_d;
  word_t            out_word_q;
  logic             out_last_q;

  logic [CNT_W-1:0] total;
  logic             last_sq;
  logic             slot_free;
  logic             take;
  logic             out_load;
  logic             out_last;
  word_t            out_word;
  rg_state_t        absorbed;
  rg_state_t        round_in;
  rg_state_t        rounded;

  always_comb begin
    if (out_words_q == '0) begin
      total = CNT_W'(1);
    end else if (out_words_q > 7'(MAX_OUTPUT_WORDS)) begin
      total = CNT_W'(MAX_OUTPUT_WORDS);
    end else begin
      total = CNT_W'(out_words_q);
    end
  end

  assign last_sq   = (CNT_W'(sq_q + 1'b1) == total);
  assign slot_free = !out_valid_q || out_ready_i;
  assign q_ready_o = (st_q == ST_IDLE);
  assign take      = q_valid_i && q_ready_o;

  // Single round unit, shared by absorb-with-round, blank rounds and squeeze
  assign absorbed = rg_absorb(hs_q, pos_q, q_entry_i.word);
  assign round_in = (st_q == ST_IDLE) ? absorbed : hs_q;
  assign rounded  = rg_round(round_in);

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (take) begin
          case (q_entry_i.op)
            OP_FINAL_PADDED: st_d = ST_ROUNDS;
            OP_FINAL_FULL:   st_d = ST_PAD;
            default:         st_d = ST_IDLE;
          endcase
        end
      end
      ST_PAD:    st_d = ST_ROUNDS;
      ST_ROUNDS: if (rnd_q == RND_W'(FINAL_ROUNDS - 1)) st_d = ST_SQUEEZE;
      ST_SQUEEZE: if (slot_free && last_sq) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    hs_d     = hs_q;
    pos_d    = pos_q;
    rnd_d    = rnd_q;
    sq_d     = sq_q;
    out_load = 1'b0;
    out_word = hs_q.mill[2];
    out_last = last_sq;
    case (st_q)
      ST_IDLE: begin
        if (take) begin
          rnd_d = '0;
          if (q_entry_i.op == OP_FINAL_PADDED) begin
            hs_d = absorbed;
          end else if (pos_q == 2'd2) begin
            hs_d  = rounded;
            pos_d = 2'd0;
          end else begin
            hs_d  = absorbed;
            pos_d = pos_q + 1'b1;
          end
        end
      end
      ST_PAD: begin
        hs_d = rg_absorb(hs_q, pos_q, PAD_WORD);
      end
      ST_ROUNDS: begin
        hs_d  = rounded;
        rnd_d = rnd_q + 1'b1;
        sq_d  = '0;
      end
      ST_SQUEEZE: begin
        if (slot_free) begin
          out_load = 1'b1;
          // even steps run a round and emit mill word 1
          if (!sq_q[0]) begin
            hs_d     = rounded;
            out_word = rounded.mill[1];
          end
          sq_d = sq_q + 1'b1;
          if (last_sq) begin
            hs_d  = '0;
            pos_d = 2'd0;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      hs_q        <= '0;
      pos_q       <= 2'd0;
      rnd_q       <= '0;
      sq_q        <= '0;
      out_valid_q <= 1'b0;
      out_words_q <= 7'(OUT_WORDS_RESET);
    end else begin
      st_q        <= st_d;
      hs_q        <= hs_d;
      pos_q       <= pos_d;
      rnd_q       <= rnd_d;
      sq_q        <= sq_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) out_words_q <= cfg_output_words_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= out_word;
      out_last_q <= out_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hash_word_o = out_word_q;
  assign last_word_o = out_last_q;

endmodule

// ===== src/radiogatun32_hash_core.sv =====
// RadioGatun[32] hash core top level: front end, item queue and back end.
// Message words enter little endian, one item per cycle while the two-entry
// queue has room; a non-final word is absorbed as the back end takes it,
// with the belt-mill round of every third word done in the same cycle. The
// final item is absorbed (followed by the pad word when it carries four
// bytes), then come FINAL_ROUNDS blank rounds from the single round unit,
// then the hash words are squeezed, one per cycle while the output register
// is free, paced by out_ready_i. The hash length is set by cfg_output_words_i
// (0 reads as 1, values above MAX_OUTPUT_WORDS are capped); the state clears
// after the last word so the next message can start right away.
module radiogatun32_hash_core #(
  parameter int MAX_OUTPUT_WORDS = rg32_pkg::MAX_OUT_WORDS_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_output_words_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rg32_pkg::word_t msg_word_i,
  input  logic [2:0]      byte_count_i,
  input  logic            final_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rg32_pkg::word_t hash_word_o,
  output logic            last_word_o
);
  import rg32_pkg::*;

  logic     q_valid;
  logic     q_ready;
  q_entry_t q_entry;

  rg32_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .msg_word_i   (msg_word_i),
    .byte_count_i (byte_count_i),
    .final_req_i  (final_req_i),
    .q_valid_o    (q_valid),
    .q_entry_o    (q_entry),
    .q_ready_i    (q_ready)
  );

  rg32_back #(
    .MAX_OUTPUT_WORDS (MAX_OUTPUT_WORDS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_output_words_i (cfg_output_words_i),
    .q_valid_i          (q_valid),
    .q_entry_i          (q_entry),
    .q_ready_o          (q_ready),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .hash_word_o        (hash_word_o),
    .last_word_o        (last_word_o)
  );

endmodule
